[src/assert_macros.svh]
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define PBSA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pbsa property violated");

// The expression must never be true at a clock edge outside reset.
`define PBSA_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("pbsa forbidden condition seen");

`endif

[src/pbsa_pkg.sv]
package pbsa_pkg;

    // Default values of the top-level parameters.
    localparam int HEAP_SLOTS_DEF  = 65536;
    localparam int NUM_CLASSES_DEF = 14;
    localparam int FIT_TRIES_DEF   = 3;

    // Fixed field widths and the size of the head-word memory.
    localparam int WORD_COUNT  = 65536;
    localparam int SLOT_W      = 16;
    localparam int LIMIT_W     = 17;
    localparam int EXP_W       = 5;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 17;

    localparam logic [LIMIT_W-1:0] HEAP_LIMIT_RST = 17'd65536;
    localparam logic [SLOT_W-1:0]  DATA_START_RST = 16'd64;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_HEAP_LIMIT = 1'b0,
        CFG_DATA_START = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_OOM = 2'd1,
        ST_BAD = 2'd2
    } t_status;

    // Controller to datapath.
    typedef struct packed {
        logic load_in;
        logic plan;
        logic commit;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic out_free;
    } t_dp_stat;

endpackage

[src/pow2_bucket_slot_allocator.sv]
// Slot allocator with power-of-two size classes and a bump pointer.
// Input channel (i_in_valid / o_in_stall) carries one request transaction:
// i_mode 0 allocates i_request_size slots, i_mode 1 frees the block at
// i_block_slot. Output channel (o_out_valid / i_out_stall) returns exactly
// one result transaction per request: granted slot, granted size, status.
// Each transaction runs through an accept step, a plan step that picks
// the class stack and reads the block head word from the head-word memory,
// and a commit step that writes the head word and the stack head or the bump
// pointer. That one memory read followed by its dependent write sets the rate;
// one transaction is in flight at a time. The commit writes the result into
// an output register, so a new request can be accepted while the previous
// result waits. If the receiver stalls with a result still held, the commit
// waits and nothing is lost.
// Synchronous reset empties all class stacks, loads the heap limit with
// 65536 and the bump pointer with 64; the head-word memory is not cleared.
// Config writes (index 0 heap limit, index 1 data start, which also reloads
// the bump pointer) must only occur while idle.
module pow2_bucket_slot_allocator #(
    parameter int HEAP_SLOTS  = pbsa_pkg::HEAP_SLOTS_DEF,
    parameter int NUM_CLASSES = pbsa_pkg::NUM_CLASSES_DEF,
    parameter int FIT_TRIES   = pbsa_pkg::FIT_TRIES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [pbsa_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [pbsa_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_mode,
    input  logic [pbsa_pkg::SLOT_W-1:0]      i_request_size,
    input  logic [pbsa_pkg::SLOT_W-1:0]      i_block_slot,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [pbsa_pkg::SLOT_W-1:0]      o_granted_slot,
    output logic [pbsa_pkg::SLOT_W-1:0]      o_granted_size,
    output logic [1:0]                       o_status
);

    import pbsa_pkg::*;

    // Commands from the sequencer and the output-register status back to it.
    t_cmd     cmd;
    t_dp_stat stat;

    pbsa_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    // The datapath holds the registers, the class stack heads, the bump
    // pointer, the head-word memory and the output register.
    pbsa_datapath #(
        .HEAP_SLOTS (HEAP_SLOTS),
        .NUM_CLASSES(NUM_CLASSES),
        .FIT_TRIES  (FIT_TRIES)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_mode        (i_mode),
        .i_request_size(i_request_size),
        .i_block_slot  (i_block_slot),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_granted_slot(o_granted_slot),
        .o_granted_size(o_granted_size),
        .o_status      (o_status)
    );

endmodule

[src/pbsa_ram.sv]
module pbsa_ram #(
    parameter int WIDTH = pbsa_pkg::SLOT_W,
    parameter int DEPTH = pbsa_pkg::WORD_COUNT
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/pbsa_datapath.sv]
module pbsa_datapath #(
    parameter int HEAP_SLOTS  = pbsa_pkg::HEAP_SLOTS_DEF,
    parameter int NUM_CLASSES = pbsa_pkg::NUM_CLASSES_DEF,
    parameter int FIT_TRIES   = pbsa_pkg::FIT_TRIES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [pbsa_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [pbsa_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_mode,
    input  logic [pbsa_pkg::SLOT_W-1:0]        i_request_size,
    input  logic [pbsa_pkg::SLOT_W-1:0]        i_block_slot,
    input  pbsa_pkg::t_cmd                     i_cmd,
    output pbsa_pkg::t_dp_stat                 o_stat,
    input  logic                               i_out_stall,
    output logic                               o_out_valid,
    output logic [pbsa_pkg::SLOT_W-1:0]        o_granted_slot,
    output logic [pbsa_pkg::SLOT_W-1:0]        o_granted_size,
    output logic [1:0]                         o_status
);

    import pbsa_pkg::*;

    localparam int CLS_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int CAP_INT = (HEAP_SLOTS < WORD_COUNT) ? HEAP_SLOTS : WORD_COUNT;
    localparam logic [LIMIT_W-1:0] LIMIT_CAP = LIMIT_W'(CAP_INT);
    localparam int ADDR_W = $clog2(WORD_COUNT);

    // Smallest e with 2^e >= req; zero requests are flagged separately.
    function automatic logic [EXP_W-1:0] ceil_exp(input logic [SLOT_W-1:0] req);
        logic [SLOT_W-1:0] m;
        logic [EXP_W-1:0]  e;
        m = req - SLOT_W'(1);
        e = '0;
        for (int b = 0; b < SLOT_W; b++) begin
            if (m[b]) begin
                e = EXP_W'(b + 1);
            end
        end
        return e;
    endfunction

    logic [LIMIT_W-1:0] r_heap_limit;
    logic [LIMIT_W-1:0] r_bump;
    logic [SLOT_W-1:0]  r_heads [NUM_CLASSES];
    logic               r_mode;
    logic               r_req_zero;
    logic [EXP_W-1:0]   r_exp;
    logic [SLOT_W-1:0]  r_slot;
    logic [CLS_W-1:0]   r_cls;
    logic               r_found;
    logic [SLOT_W-1:0]  r_top;
    logic               r_out_valid;
    logic [SLOT_W-1:0]  r_out_slot;
    logic [SLOT_W-1:0]  r_out_size;
    t_status            r_out_status;

    logic [NUM_CLASSES-1:0] hit;
    logic [CLS_W-1:0]       pick;
    logic                   stack_ok;
    logic                   found;
    logic [SLOT_W-1:0]      ram_rdata;
    logic [SLOT_W-1:0]      ram_raddr;
    logic                   ram_we;
    logic [SLOT_W-1:0]      ram_waddr;
    logic [SLOT_W-1:0]      ram_wdata;
    logic [3:0]             hdr_pos;
    logic                   hdr_ok;
    logic [CLS_W-1:0]       hdr_cls;
    logic [CLS_W-1:0]       head_idx;
    logic [SLOT_W-1:0]      head_rd;
    logic                   head_we;
    logic [CLS_W-1:0]       head_widx;
    logic [SLOT_W-1:0]      head_wdata;
    logic [SLOT_W-1:0]      size16;
    logic [SLOT_W-1:0]      csize;
    logic [LIMIT_W:0]       bump_sum;
    logic [LIMIT_W-1:0]     lim;
    logic                   bump_fit;
    logic                   bump_we;
    logic [SLOT_W-1:0]      res_slot;
    logic [SLOT_W-1:0]      res_size;
    t_status                res_status;
    logic                   out_free;

    // Search the fit window for the lowest non-empty class.
    always_comb begin
        hit      = '0;
        pick     = '0;
        stack_ok = !r_req_zero && (r_exp >= EXP_W'(2)) && (r_exp <= EXP_W'(15));
        for (int j = 0; j < NUM_CLASSES; j++) begin
            hit[j] = stack_ok && (r_heads[j] != '0) && (int'(r_exp) <= j + 2)
                && (j + 2 < int'(r_exp) + FIT_TRIES);
        end
        for (int j = NUM_CLASSES - 1; j >= 0; j--) begin
            if (hit[j]) begin
                pick = CLS_W'(j);
            end
        end
    end

    assign found = |hit;

    // Size header check for a free.
    always_comb begin
        hdr_pos = '0;
        for (int b = 0; b < SLOT_W; b++) begin
            if (ram_rdata[b]) begin
                hdr_pos = 4'(b);
            end
        end
        hdr_ok = (ram_rdata >= SLOT_W'(4))
            && ((ram_rdata & (ram_rdata - SLOT_W'(1))) == '0)
            && (int'(hdr_pos) - 2 < NUM_CLASSES);
        hdr_cls = CLS_W'(int'(hdr_pos) - 2);
    end

    // One read port on the stack heads, shared by the pop and the push.
    assign head_idx  = i_cmd.plan ? pick : hdr_cls;
    assign head_rd   = r_heads[head_idx];
    assign ram_raddr = (r_mode == MODE_FREE) ? r_slot : head_rd;

    assign size16   = SLOT_W'(1) << r_exp[3:0];
    assign csize    = SLOT_W'(32'd1 << (int'(r_cls) + 2));
    assign bump_sum = {1'b0, r_bump} + (LIMIT_W + 1)'(size16);
    assign lim      = (r_heap_limit < LIMIT_CAP) ? r_heap_limit : LIMIT_CAP;
    assign bump_fit = bump_sum < {1'b0, lim};

    always_comb begin
        ram_we     = 1'b0;
        ram_waddr  = r_slot;
        ram_wdata  = '0;
        head_we    = 1'b0;
        head_widx  = r_cls;
        head_wdata = '0;
        bump_we    = 1'b0;
        res_slot   = '0;
        res_size   = '0;
        res_status = ST_OK;
        if (r_mode == MODE_FREE) begin
            if (r_slot == '0) begin
                res_status = ST_BAD;
            end else if (hdr_ok) begin
                ram_we     = 1'b1;
                ram_waddr  = r_slot;
                ram_wdata  = head_rd;
                head_we    = 1'b1;
                head_widx  = hdr_cls;
                head_wdata = r_slot;
            end else begin
                res_status = ST_BAD;
            end
        end else if (r_req_zero) begin
            res_status = ST_BAD;
        end else if (r_exp > EXP_W'(15)) begin
            res_status = ST_OOM;
        end else if (r_found) begin
            ram_we     = 1'b1;
            ram_waddr  = r_top;
            ram_wdata  = csize;
            head_we    = 1'b1;
            head_widx  = r_cls;
            head_wdata = ram_rdata;
            res_slot   = r_top;
            res_size   = csize;
        end else if (bump_fit) begin
            ram_we    = 1'b1;
            ram_waddr = r_bump[SLOT_W-1:0];
            ram_wdata = size16;
            bump_we   = 1'b1;
            res_slot  = r_bump[SLOT_W-1:0];
            res_size  = size16;
        end else begin
            res_status = ST_OOM;
        end
        ram_we  = ram_we && i_cmd.commit;
        head_we = head_we && i_cmd.commit;
        bump_we = bump_we && i_cmd.commit;
    end

    pbsa_ram #(
        .WIDTH(SLOT_W),
        .DEPTH(WORD_COUNT)
    ) u_head_words (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr[ADDR_W-1:0]),
        .i_wdata(ram_wdata),
        .i_re   (i_cmd.plan),
        .i_raddr(ram_raddr[ADDR_W-1:0]),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_mode     <= i_mode;
            r_slot     <= i_block_slot;
            r_req_zero <= (i_request_size == '0);
            r_exp      <= ceil_exp(i_request_size);
        end
        if (i_cmd.plan) begin
            r_cls   <= pick;
            r_found <= found;
            r_top   <= head_rd;
        end
        if (i_cmd.commit) begin
            r_out_slot   <= res_slot;
            r_out_size   <= res_size;
            r_out_status <= res_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_limit <= HEAP_LIMIT_RST;
            r_bump       <= LIMIT_W'(DATA_START_RST);
            r_out_valid  <= 1'b0;
            for (int j = 0; j < NUM_CLASSES; j++) begin
                r_heads[j] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_HEAP_LIMIT: r_heap_limit <= i_cfg_data[LIMIT_W-1:0];
                    CFG_DATA_START: r_bump <= LIMIT_W'(i_cfg_data[SLOT_W-1:0]);
                    default: ;
                endcase
            end
            if (bump_we) begin
                r_bump <= bump_sum[LIMIT_W-1:0];
            end
            if (head_we) begin
                r_heads[head_widx] <= head_wdata;
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign out_free        = !r_out_valid || !i_out_stall;
    assign o_stat.out_free = out_free;
    assign o_out_valid     = r_out_valid;
    assign o_granted_slot  = r_out_slot;
    assign o_granted_size  = r_out_size;
    assign o_status        = r_out_status;

endmodule

[src/pbsa_ctrl.sv]
module pbsa_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  pbsa_pkg::t_dp_stat i_stat,
    output pbsa_pkg::t_cmd     o_cmd
);

    import pbsa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_PLAN   = 3'b010,
        S_COMMIT = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_PLAN;
                end
            end
            S_PLAN: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_cmd.load_in = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.plan    = (r_state == S_PLAN);
    assign o_cmd.commit  = (r_state == S_COMMIT) && i_stat.out_free;

endmodule

[src/pbsa_chk.sv]
`include "assert_macros.svh"

module pbsa_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [pbsa_pkg::SLOT_W-1:0] o_granted_slot,
    input logic [pbsa_pkg::SLOT_W-1:0] o_granted_size,
    input logic [1:0]                  o_status
);

    import pbsa_pkg::*;

    // A held result does not change while the receiver stalls.
    `PBSA_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_granted_slot) && $stable(o_granted_size) && $stable(o_status))

    // Failed or refused requests grant nothing.
    `PBSA_ASSERT(a_fail_empty, i_clk, i_rst_n, o_out_valid && o_status != ST_OK |-> o_granted_slot == '0 && o_granted_size == '0)

    // Any granted size is a power of two.
    `PBSA_ASSERT(a_size_pow2, i_clk, i_rst_n, o_out_valid && o_granted_size != '0 |-> $onehot(o_granted_size))

    // Only one request is worked on at a time.
    `PBSA_NEVER(a_one_in_flight, i_clk, i_rst_n, $past(i_in_valid && !o_in_stall) && !o_in_stall)

endmodule

bind pow2_bucket_slot_allocator pbsa_chk u_pbsa_chk (.*);

[test/pow2_bucket_slot_allocator_tb.sv]
`timescale 1ns / 1ps

module pow2_bucket_slot_allocator_tb;

    // Self-checking testbench for the power-of-two slot allocator.
    //
    // A predictor inside this module keeps its own copy of the allocator state:
    // the bump pointer, the class stack heads and every block head word. Each
    // request transaction is run through it when the block accepts it. The
    // predicted result is queued, and the receiver process compares every
    // result transaction with the oldest entry, field by field.
    //
    // The head-word memory is not cleared by reset. The stimulus therefore
    // tracks which head words have been written, and it never issues a
    // request that would read a word that was never written. When a random
    // pick would do that, a harmless request takes its place.

    import pbsa_pkg::*;

    localparam int NUM_CLASSES = NUM_CLASSES_DEF;
    localparam int FIT_TRIES   = FIT_TRIES_DEF;

    // One predicted result transaction.
    typedef struct {
        logic [SLOT_W-1:0] granted_slot;
        logic [SLOT_W-1:0] granted_size;
        t_status           status;
    } t_grant;

    logic                   i_clk;
    logic                   i_rst_n        = 1'b0;
    logic                   i_cfg_we       = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data     = '0;
    logic                   i_in_valid     = 1'b0;
    logic                   o_in_stall;
    logic                   i_mode         = MODE_ALLOC;
    logic [SLOT_W-1:0]      i_request_size = '0;
    logic [SLOT_W-1:0]      i_block_slot   = '0;
    logic                   o_out_valid;
    logic                   i_out_stall    = 1'b0;
    logic [SLOT_W-1:0]      o_granted_slot;
    logic [SLOT_W-1:0]      o_granted_size;
    logic [1:0]             o_status;

    // Predictor state.
    logic [LIMIT_W-1:0] heap_limit_reg;
    logic [LIMIT_W-1:0] bump_ptr;
    logic [SLOT_W-1:0]  class_head [NUM_CLASSES];
    logic [SLOT_W-1:0]  head_word [WORD_COUNT];
    bit                 word_written [WORD_COUNT];

    // Results still owed by the block, oldest first.
    t_grant expected_grants [$];

    // Blocks that are granted and not yet freed, and blocks freed so far.
    logic [SLOT_W-1:0] live_blocks [$];
    logic [SLOT_W-1:0] freed_blocks [$];

    int error_count   = 0;
    // Set by a test to make the receiver hold off for that many cycles.
    int long_hold_req = 0;
    // While set, neither side inserts random idle cycles; a requested long hold still applies.
    bit no_gaps       = 1'b0;

    pow2_bucket_slot_allocator u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_request_size (i_request_size),
        .i_block_slot   (i_block_slot),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_granted_slot (o_granted_slot),
        .o_granted_size (o_granted_size),
        .o_status       (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog. The slowest legal run is far below this bound.
    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Exponent of the smallest power of two that is at least req.
    function automatic int size_exp(input logic [SLOT_W-1:0] req);
        int e;
        e = 0;
        while ((32'd1 << e) < req)
            e++;
        return e;
    endfunction

    // The class stack that a request of 2^e slots would pop, or -1 when the
    // request falls through to the bump pointer. Sizes 1 and 2 never use a
    // stack, and only FIT_TRIES classes starting at the exact fit are tried.
    function automatic int serving_class(input int e);
        int idx;
        if (e < 2)
            return -1;
        for (idx = e - 2; idx < e - 2 + FIT_TRIES && idx < NUM_CLASSES; idx++)
            if (class_head[idx] != '0)
                return idx;
        return -1;
    endfunction

    // True when the request would read a head word that was never written.
    function automatic bit touches_unwritten(input logic mode,
                                             input logic [SLOT_W-1:0] req_size,
                                             input logic [SLOT_W-1:0] blk_slot);
        int e;
        int idx;
        if (mode == MODE_FREE)
            return blk_slot != '0 && !word_written[blk_slot];
        if (req_size == '0)
            return 1'b0;
        e = size_exp(req_size);
        if (e > 15)
            return 1'b0;
        idx = serving_class(e);
        return idx >= 0 && !word_written[class_head[idx]];
    endfunction

    // Applies one accepted request to the predictor state and returns the
    // result that the block must produce for it.
    function automatic t_grant apply_request(input logic mode,
                                             input logic [SLOT_W-1:0] req_size,
                                             input logic [SLOT_W-1:0] blk_slot);
        t_grant            r;
        int                e;
        int                idx;
        int                fit_end;
        int                limit;
        logic [SLOT_W-1:0] hdr;
        logic [SLOT_W-1:0] top;
        r.granted_slot = '0;
        r.granted_size = '0;
        r.status       = ST_OK;

        if (mode == MODE_FREE) begin
            // Slot 0 is the empty-stack marker, so it can never be freed.
            // A header below 4 or not a power of two is a bad free. A second
            // free of the same block reads its stack link as the header.
            hdr = head_word[blk_slot];
            if (blk_slot == '0 || hdr < 4 || (hdr & (hdr - 1'b1)) != '0) begin
                r.status = ST_BAD;
                return r;
            end
            e = size_exp(hdr);
            if (e - 2 >= NUM_CLASSES) begin
                r.status = ST_BAD;
                return r;
            end
            head_word[blk_slot] = class_head[e - 2];
            class_head[e - 2]   = blk_slot;
            return r;
        end

        if (req_size == '0) begin
            r.status = ST_BAD;
            return r;
        end
        e = size_exp(req_size);
        if (e > 15) begin
            r.status = ST_OOM;
            return r;
        end

        idx = serving_class(e);
        if (idx >= 0) begin
            // Pop: the head word holds the next link and then the size header.
            top                = class_head[idx];
            class_head[idx]    = head_word[top];
            r.granted_slot     = top;
            r.granted_size     = SLOT_W'(1 << (idx + 2));
            head_word[top]     = r.granted_size;
            word_written[top]  = 1'b1;
            return r;
        end

        // The bump allocation must end strictly below the effective limit.
        limit = int'(heap_limit_reg);
        if (limit > HEAP_SLOTS_DEF)
            limit = HEAP_SLOTS_DEF;
        if (limit > WORD_COUNT)
            limit = WORD_COUNT;
        fit_end = int'(bump_ptr) + (1 << e);
        if (fit_end < limit) begin
            r.granted_slot               = bump_ptr[SLOT_W-1:0];
            r.granted_size               = SLOT_W'(1 << e);
            head_word[r.granted_slot]    = r.granted_size;
            word_written[r.granted_slot] = 1'b1;
            bump_ptr                     = LIMIT_W'(fit_end);
        end else begin
            r.status = ST_OOM;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Idle cycles before the next transaction: mostly none or a few, now
    // and then a long one.
    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Sizes are mostly small so that the heap lasts; the rest covers large
    // blocks, zero size and sizes that round above the largest class.
    function automatic logic [SLOT_W-1:0] random_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return SLOT_W'($urandom_range(1, 64));
        if (r < 80)
            return SLOT_W'($urandom_range(65, 4096));
        if (r < 88)
            return SLOT_W'($urandom_range(4097, 32768));
        if (r < 91)
            return '0;
        return SLOT_W'($urandom_range(32769, 65535));
    endfunction

    // Offers one request transaction, waits until the block takes it and
    // records the predicted result. The valid line is left high so that a
    // back-to-back request needs no second assignment in the same step.
    task automatic send_request(input logic mode, input logic [SLOT_W-1:0] req_size,
                                input logic [SLOT_W-1:0] blk_slot, output t_grant grant);
        int gap;
        int i;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_mode         <= mode;
        i_request_size <= req_size;
        i_block_slot   <= blk_slot;
        do
            @(posedge i_clk);
        while (o_in_stall);

        grant = apply_request(mode, req_size, blk_slot);
        expected_grants.push_back(grant);
        if (grant.status == ST_OK) begin
            if (mode == MODE_ALLOC) begin
                live_blocks.push_back(grant.granted_slot);
            end else begin
                freed_blocks.push_back(blk_slot);
                for (i = 0; i < live_blocks.size(); i++) begin
                    if (live_blocks[i] == blk_slot) begin
                        live_blocks.delete(i);
                        break;
                    end
                end
            end
        end
    endtask

    task automatic alloc_req(input logic [SLOT_W-1:0] req_size, output t_grant grant);
        send_request(MODE_ALLOC, req_size, SLOT_W'($urandom), grant);
    endtask

    task automatic free_req(input logic [SLOT_W-1:0] blk_slot);
        t_grant g;
        send_request(MODE_FREE, SLOT_W'($urandom), blk_slot, g);
    endtask

    // Drops valid and waits until every owed result has come back, then waits
    // further so that the last commit has landed in the block.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_grants.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Register write, only while the block is idle.
    task automatic write_config(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_HEAP_LIMIT) begin
            heap_limit_reg = value;
        end else begin
            // Writing the data start also reloads the bump pointer.
            bump_ptr = {1'b0, value[SLOT_W-1:0]};
        end
        @(posedge i_clk);
    endtask

    // Random traffic: allocations, frees of live blocks (the normal life
    // cycle), repeated frees of freed blocks and frees of arbitrary slots.
    // A pick that would read an unwritten head word becomes a free of slot 0
    // or a bump-only allocation of size 1 or 2.
    task automatic run_random_mix(input int count);
        t_grant            g;
        int                k;
        int                pick;
        logic              mode;
        logic [SLOT_W-1:0] sz;
        logic [SLOT_W-1:0] sl;
        for (k = 0; k < count; k++) begin
            sz   = SLOT_W'($urandom);
            sl   = SLOT_W'($urandom);
            mode = MODE_FREE;
            pick = $urandom_range(0, 99);
            if (pick < 50 || (pick < 85 && live_blocks.size() == 0)) begin
                mode = MODE_ALLOC;
                sz   = random_size();
            end else if (pick < 85) begin
                sl = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
            end else if (pick < 93 && freed_blocks.size() != 0) begin
                sl = freed_blocks[$urandom_range(0, freed_blocks.size() - 1)];
            end
            if (touches_unwritten(mode, sz, sl)) begin
                if (mode == MODE_FREE)
                    sl = '0;
                else
                    sz = SLOT_W'($urandom_range(1, 2));
            end
            send_request(mode, sz, sl, g);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Zero size, sizes that round above the largest class, and the largest
    // class itself through the bump pointer and then through its stack.
    task automatic test_request_extremes();
        t_grant g;
        t_grant big;
        alloc_req(16'd0, g);
        alloc_req(16'd32769, g);
        alloc_req(16'hFFFF, g);
        alloc_req(16'd32768, big);
        free_req(big.granted_slot);
        alloc_req(16'd32768, g);
        free_req(g.granted_slot);
    endtask

    // A request can be served by the next larger classes, but only within
    // the fit window; beyond it the bump pointer takes over.
    task automatic test_larger_class_fit();
        t_grant g;
        alloc_req(16'd16, g);
        free_req(g.granted_slot);
        alloc_req(16'd4, g);
        alloc_req(16'd64, g);
        free_req(g.granted_slot);
        alloc_req(16'd4, g);
        free_req(16'd0);
    endtask

    // Sizes 1 and 2 bypass the stacks; freeing such a block is a bad free
    // because its header is below the smallest class. Size 3 rounds to 4.
    task automatic test_small_sizes();
        t_grant one;
        t_grant g;
        alloc_req(16'd1, one);
        alloc_req(16'd2, g);
        alloc_req(16'd3, g);
        free_req(one.granted_slot);
    endtask

    // A freed block is handed out again, and freeing it twice in a row reads
    // the empty-stack link as its header.
    task automatic test_reuse_and_double_free();
        t_grant g;
        alloc_req(16'd5, g);
        free_req(g.granted_slot);
        alloc_req(16'd8, g);
        free_req(g.granted_slot);
        free_req(g.granted_slot);
    endtask

    task automatic test_back_to_back();
        no_gaps = 1'b1;
        run_random_mix(30);
        no_gaps = 1'b0;
        wait_idle();
    endtask

    // The receiver holds off for a long stretch while requests keep coming,
    // so the block fills up and stalls its input.
    task automatic test_output_hold_off();
        t_grant g;
        int     k;
        long_hold_req = 80;
        no_gaps       = 1'b1;
        for (k = 0; k < 12; k++)
            alloc_req(SLOT_W'($urandom_range(1, 40)), g);
        no_gaps = 1'b0;
        wait_idle();
    endtask

    // Bump region close to a low heap limit: out of memory comes quickly.
    task automatic test_tight_heap();
        write_config(CFG_HEAP_LIMIT, 17'd40300);
        write_config(CFG_DATA_START, 17'd40000);
        run_random_mix(70);
        wait_idle();
    endtask

    // Smallest settings: no bump allocation fits, only the stacks serve.
    task automatic test_empty_heap();
        write_config(CFG_HEAP_LIMIT, 17'd1);
        write_config(CFG_DATA_START, 17'd1);
        run_random_mix(40);
        wait_idle();
    endtask

    // Heap limit above the memory size is clamped; blocks at odd slots and
    // slots with the top bit set.
    task automatic test_high_slots();
        t_grant g;
        write_config(CFG_HEAP_LIMIT, 17'h1FFFF);
        write_config(CFG_DATA_START, 17'h07FFF);
        alloc_req(16'd4, g);
        free_req(g.granted_slot);
        run_random_mix(80);
        wait_idle();
    endtask

    // Data start at the top leaves no room; at zero the bump pointer can
    // grant slot 0, which still cannot be freed.
    task automatic test_data_start_extremes();
        t_grant g;
        write_config(CFG_HEAP_LIMIT, 17'd65536);
        write_config(CFG_DATA_START, 17'hFFFF);
        run_random_mix(8);
        wait_idle();
        write_config(CFG_DATA_START, 17'd0);
        alloc_req(16'd4, g);
        free_req(g.granted_slot);
        run_random_mix(8);
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls and the result check
    // ------------------------------------------------------------------
    initial begin : receiver
        t_grant want;
        int     stall_left;
        int     run_left;
        stall_left = 0;
        run_left   = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                if (expected_grants.size() == 0) begin
                    $error("result transaction with no request outstanding");
                    error_count++;
                end else begin
                    want = expected_grants.pop_front();
                    if (o_granted_slot !== want.granted_slot) begin
                        $error("granted_slot: expected %0d, got %0d",
                               want.granted_slot, o_granted_slot);
                        error_count++;
                    end
                    if (o_granted_size !== want.granted_size) begin
                        $error("granted_size: expected %0d, got %0d",
                               want.granted_size, o_granted_size);
                        error_count++;
                    end
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        error_count++;
                    end
                end
            end

            if (long_hold_req > 0) begin
                stall_left    = long_hold_req;
                long_hold_req = 0;
            end
            if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else if (run_left > 0 || no_gaps) begin
                i_out_stall <= 1'b0;
                if (run_left > 0)
                    run_left--;
            end else begin
                stall_left = pick_gap();
                run_left   = $urandom_range(1, 8);
                if (stall_left > 0) begin
                    i_out_stall <= 1'b1;
                    stall_left--;
                end else begin
                    i_out_stall <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : main
        heap_limit_reg = HEAP_LIMIT_RST;
        bump_ptr       = {1'b0, DATA_START_RST};
        foreach (class_head[k])
            class_head[k] = '0;
        foreach (head_word[k]) begin
            head_word[k]    = '0;
            word_written[k] = 1'b0;
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_request_extremes();
        test_larger_class_fit();
        test_small_sizes();
        test_reuse_and_double_free();
        wait_idle();
        test_back_to_back();
        test_output_hold_off();
        run_random_mix(180);
        wait_idle();
        test_tight_heap();
        test_empty_heap();
        test_high_slots();
        test_data_start_extremes();

        repeat (10) @(posedge i_clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
